>>> design/sseg_pkg.sv
`timescale 1ns / 1ps

package sseg_pkg;

  // Item codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_SCAN   = 3'd0,
    MODE_ANIM   = 3'd1,
    MODE_SHOW   = 3'd2,
    MODE_SETBIT = 3'd3,
    MODE_SELECT = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    LED_ROTATE = 2'd0,
    LED_ALT    = 2'd1,
    LED_BLINK  = 2'd2,
    LED_ERROR  = 2'd3
  } led_mode_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [13:0] value;
    logic [1:0]  led_mode_sel;
    logic        bit_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_enables_n;
    logic       led_enable_n;
    logic [7:0] segment_bus;
  } out_word_t;

  // Registered item with the decimal quotients already formed.
  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  led_mode_sel;
    logic        bit_value;
    logic [13:0] num;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
  } stage_t;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam logic [2:0]  LED_SLOT    = 3'd4;
  localparam logic [13:0] VALUE_MAX   = 14'd9999;

  // Reciprocal constants, exact for every value up to VALUE_MAX.
  localparam logic [15:0] RECIP_10   = 16'd52429;  // shift 19
  localparam logic [12:0] RECIP_100  = 13'd5243;   // shift 19
  localparam logic [14:0] RECIP_1000 = 15'd16778;  // shift 24

  localparam logic [7:0] DOT_PATTERN   = 8'h7F;
  localparam logic [7:0] BLANK_PATTERN = 8'hFF;
  localparam logic [7:0] ALT_A         = 8'h5A;
  localparam logic [7:0] ALT_B         = 8'hA5;
  localparam logic [7:0] ROTATE_LOAD   = 8'h0F;
  localparam logic [7:0] LED_RESET     = 8'hF0;
  localparam logic [7:0] DIG0_RESET    = 8'h7F;
  localparam logic [7:0] DIG1_RESET    = 8'hF9;
  localparam logic [7:0] DIG2_RESET    = 8'hA4;
  localparam logic [7:0] DIG3_RESET    = 8'hB0;

  // Active-low seven-segment glyph of a decimal digit.
  function automatic logic [7:0] dec_glyph(input logic [3:0] d);
    logic [7:0] g;
    case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = 8'hFF;
    endcase
    return g;
  endfunction

endpackage

>>> design/sseg_in_stage.sv
`timescale 1ns / 1ps

module sseg_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sseg_pkg::in_word_t in_data,
  input  logic               advance,
  output logic               stage_valid,
  output sseg_pkg::stage_t   stage_item
);

  logic               valid_r, valid_nxt;
  sseg_pkg::stage_t   item_r, item_nxt;
  logic [13:0]        num;
  logic [29:0]        prod10;
  logic [26:0]        prod100;
  logic [28:0]        prod1000;

  assign in_ready = !valid_r || advance;

  // Clamp, then divide by 10, 100 and 1000 with reciprocal multiplies.
  always_comb begin
    num      = (in_data.value > sseg_pkg::VALUE_MAX) ? sseg_pkg::VALUE_MAX : in_data.value;
    prod10   = 30'(num) * 30'(sseg_pkg::RECIP_10);
    prod100  = 27'(num) * 27'(sseg_pkg::RECIP_100);
    prod1000 = 29'(num) * 29'(sseg_pkg::RECIP_1000);

    item_nxt.mode         = in_data.mode;
    item_nxt.led_mode_sel = in_data.led_mode_sel;
    item_nxt.bit_value    = in_data.bit_value;
    item_nxt.num          = num;
    item_nxt.q10          = prod10[28:19];
    item_nxt.q100         = prod100[25:19];
    item_nxt.q1000        = prod1000[27:24];
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

`ifndef ASSERT_OFF
  // A held word is never dropped while the core cannot take it.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !advance |=> valid_r)
    else $error("staged word lost while stalled");
  // Advancing only happens with a staged word present.
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> valid_r)
    else $error("advance without staged word");
`endif

endmodule

>>> design/sseg_core.sv
`timescale 1ns / 1ps

module sseg_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                apply,
  input  sseg_pkg::stage_t    item,
  output sseg_pkg::out_word_t drive
);

  logic [7:0]          digit_r   [sseg_pkg::DIGIT_COUNT];
  logic [7:0]          digit_nxt [sseg_pkg::DIGIT_COUNT];
  logic [7:0]          led_r, led_nxt;
  logic [2:0]          slot_r, slot_nxt;
  logic [2:0]          phase_r, phase_nxt;
  sseg_pkg::led_mode_t lmode_r, lmode_nxt;
  logic [3:0]          dig_en_r, dig_en_nxt;
  logic                led_en_r, led_en_nxt;
  logic [7:0]          bus_r, bus_nxt;
  logic [6:0]          d1;
  logic [9:0]          d2;
  logic [13:0]         d3;
  logic [7:0]          fill;

  // Remainders from neighboring quotients: x - 10 * (x / 10).
  always_comb begin
    d1 = item.q100 - 7'({item.q1000, 3'b000} + {item.q1000, 1'b0});
    d2 = item.q10 - 10'({item.q100, 3'b000} + {item.q100, 1'b0});
    d3 = item.num - ({1'b0, item.q10, 3'b000} + {3'b000, item.q10, 1'b0});
  end

  always_comb begin
    for (int i = 0; i < sseg_pkg::DIGIT_COUNT; i++) begin
      digit_nxt[i] = digit_r[i];
    end
    led_nxt    = led_r;
    slot_nxt   = slot_r;
    phase_nxt  = phase_r;
    lmode_nxt  = lmode_r;
    dig_en_nxt = dig_en_r;
    led_en_nxt = led_en_r;
    bus_nxt    = bus_r;
    fill       = phase_r[0] ? sseg_pkg::DOT_PATTERN : sseg_pkg::BLANK_PATTERN;

    unique case (item.mode)
      sseg_pkg::MODE_SCAN: begin
        if (slot_r < sseg_pkg::LED_SLOT) begin
          led_en_nxt = 1'b1;
          bus_nxt    = digit_r[slot_r[1:0]];
          dig_en_nxt = ~(4'b0001 << slot_r[1:0]);
          slot_nxt   = slot_r + 3'd1;
        end else begin
          dig_en_nxt = 4'hF;
          bus_nxt    = led_r;
          led_en_nxt = 1'b0;
          slot_nxt   = 3'd0;
        end
      end
      sseg_pkg::MODE_ANIM: begin
        unique case (lmode_r)
          sseg_pkg::LED_ROTATE: led_nxt = {led_r[6:0], led_r[7]};
          sseg_pkg::LED_ALT:    led_nxt = phase_r[2] ? sseg_pkg::ALT_A : sseg_pkg::ALT_B;
          sseg_pkg::LED_BLINK:  led_nxt = phase_r[1] ? sseg_pkg::ALT_A : sseg_pkg::BLANK_PATTERN;
          sseg_pkg::LED_ERROR: begin
            led_nxt = sseg_pkg::BLANK_PATTERN;
            for (int i = 0; i < sseg_pkg::DIGIT_COUNT; i++) begin
              digit_nxt[i] = fill;
            end
          end
          default: led_nxt = led_r;
        endcase
        phase_nxt = phase_r + 3'd1;
      end
      sseg_pkg::MODE_SHOW: begin
        digit_nxt[0] = sseg_pkg::dec_glyph(item.q1000);
        digit_nxt[1] = sseg_pkg::dec_glyph(d1[3:0]);
        digit_nxt[2] = sseg_pkg::dec_glyph(d2[3:0]);
        digit_nxt[3] = sseg_pkg::dec_glyph(d3[3:0]);
      end
      sseg_pkg::MODE_SETBIT: begin
        led_nxt[7] = item.bit_value;
      end
      sseg_pkg::MODE_SELECT: begin
        if (sseg_pkg::led_mode_t'(item.led_mode_sel) == sseg_pkg::LED_ROTATE) begin
          led_nxt = sseg_pkg::ROTATE_LOAD;
        end
        lmode_nxt = sseg_pkg::led_mode_t'(item.led_mode_sel);
      end
      default: begin
        led_nxt = led_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r[0] <= sseg_pkg::DIG0_RESET;
      digit_r[1] <= sseg_pkg::DIG1_RESET;
      digit_r[2] <= sseg_pkg::DIG2_RESET;
      digit_r[3] <= sseg_pkg::DIG3_RESET;
      led_r      <= sseg_pkg::LED_RESET;
      slot_r     <= 3'd0;
      phase_r    <= 3'd0;
      lmode_r    <= sseg_pkg::LED_ROTATE;
      dig_en_r   <= 4'hF;
      led_en_r   <= 1'b1;
      bus_r      <= 8'hFF;
    end else if (apply) begin
      for (int i = 0; i < sseg_pkg::DIGIT_COUNT; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
      led_r    <= led_nxt;
      slot_r   <= slot_nxt;
      phase_r  <= phase_nxt;
      lmode_r  <= lmode_nxt;
      dig_en_r <= dig_en_nxt;
      led_en_r <= led_en_nxt;
      bus_r    <= bus_nxt;
    end
  end

  assign drive.digit_enables_n = dig_en_r;
  assign drive.led_enable_n    = led_en_r;
  assign drive.segment_bus     = bus_r;

`ifndef ASSERT_OFF
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= sseg_pkg::LED_SLOT)
    else $error("scan slot out of range");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(~dig_en_r) && (led_en_r || dig_en_r == 4'hF))
    else $error("more than one display element driven");
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    apply && item.mode != sseg_pkg::MODE_SCAN |=> $stable(dig_en_r) && $stable(bus_r))
    else $error("drive changed on a non-scan word");
`endif

endmodule

>>> design/seven_segment_scan_with_led_animation.sv
`timescale 1ns / 1ps

// Multiplexed driver for four common-anode seven-segment digits and an
// eight-LED bar sharing one active-low segment bus.
// Input channel (in_valid / in_ready / in_data): each word is a scan tick,
// an animation tick, a decimal value to show, a write of LED bit 7 or an
// LED mode selection. The sender paces the ticks.
// Result channel (out_valid / out_ready / out_data): every input word yields
// exactly one result word holding the digit enables, LED enable and bus
// value after that word has been applied. Only scan ticks change them.
// An accepted word goes to the staging register, then to the result register
// once that is free. Throughput: one word per cycle while results are taken;
// the decimal split is a set of reciprocal multiplies ahead of the staging
// register, so the state update is one pass.
// The input side keeps accepting while a result waits: the staging register
// and the result register decouple the two channels, and a stalled receiver
// holds the result steady and back-pressures only once both are full.
// Reset (synchronous, active low) empties both registers, turns all digits
// and the LED bar off, loads the power-on digit and LED patterns and
// selects the rotate animation.

module seven_segment_scan_with_led_animation (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sseg_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sseg_pkg::out_word_t out_data
);

  logic             stage_valid;
  sseg_pkg::stage_t stage_item;
  logic             advance;
  logic             out_valid_r, out_valid_nxt;

  // A staged word moves into the state and result registers whenever the
  // result register is empty or its word is being taken this cycle.
  assign advance = stage_valid && (!out_valid_r || out_ready);

  sseg_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // The core's drive registers double as the result payload register.
  sseg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .apply (advance),
    .item  (stage_item),
    .drive (out_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stage_valid)
    else $error("accepted word not staged");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("applied word produced no result");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule
